// ===== rtl/lfhtc_pkg.sv =====
// Package: shared widths, command and verdict codes for the trace checker.
package lfhtc_pkg;
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = 32;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  localparam logic [2:0] VERD_IMPOSSIBLE = 3'd0;
  localparam logic [2:0] VERD_STACK      = 3'd1;
  localparam logic [2:0] VERD_QUEUE      = 3'd2;
  localparam logic [2:0] VERD_PRIO       = 3'd3;
  localparam logic [2:0] VERD_NOT_SURE   = 3'd4;

  typedef struct packed {
    logic [1:0]          command;
    logic signed [DW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] verdict;
    logic       overflowed;
  } out_item_t;
endpackage

// ===== rtl/lfhtc_if.sv =====
// Interfaces: valid/ready channels for trace items and verdict items.
interface lfhtc_in_if (input logic clk);
  logic               valid;
  logic               ready;
  lfhtc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lfhtc_out_if (input logic clk);
  logic                valid;
  logic                ready;
  lfhtc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lfhtc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module lfhtc_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/lifo_fifo_heap_trace_checker_unit.sv =====
// Top level: stack / queue / max-heap discipline checker over a push-pop trace.
//
// Takes one trace item (push, pop, end) at a time and returns a verdict item
// on each end command. Three 1024-word memories hold the stack, the queue
// ring and the binary max-heap; each has one write and one registered read
// port. A push writes the stack and queue, then climbs the heap: it reads the
// parent, compares, and moves the parent down until the value settles or
// reaches the root. A pop compares the observed value with the stack top, the
// queue head and the heap root, reads the last heap word, and sifts it down
// from the root (each level reads two children through the single heap read
// port, then writes); a pop that empties the stores skips the sift-down. End,
// unused codes, a push into full stores and a pop on empty stores are handled
// in idle. No clearing pass is needed after reset: the fill count alone bounds
// what is read. The verdict waits in an output register; while it waits
// unaccepted, no new item is taken.
module lifo_fifo_heap_trace_checker_unit (
  input logic clk,
  input logic rst_n,
  lfhtc_in_if.sink    in_ch,
  lfhtc_out_if.source out_ch
);
  localparam int unsigned AW = lfhtc_pkg::AW;
  localparam int unsigned CW = lfhtc_pkg::CW;
  localparam int unsigned DW = lfhtc_pkg::DW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRD   = 4'd1;  // push: parent read issued
  localparam logic [3:0] S_PCMP  = 4'd2;  // push: compare with parent
  localparam logic [3:0] S_POPA  = 4'd3;  // pop: compare top, last read issued
  localparam logic [3:0] S_POPB  = 4'd4;  // unused state code
  localparam logic [3:0] S_DRL   = 4'd5;  // sift-down: left read issued
  localparam logic [3:0] S_DRR   = 4'd6;  // sift-down: right read issued
  localparam logic [3:0] S_DCMP  = 4'd7;  // sift-down: decide
  localparam logic [3:0] S_POPC  = 4'd8;  // pop: latch last word

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic          lifo_ok_r, lifo_ok_nxt, fifo_ok_r, fifo_ok_nxt;
  logic          heap_ok_r, heap_ok_nxt, ovf_r, ovf_nxt;
  logic [CW-1:0] pos_r, pos_nxt;       // current heap slot during a sift
  logic [DW-1:0] val_r, val_nxt;       // value being sifted / observed
  logic [DW-1:0] obs_r, obs_nxt;       // observed pop value
  logic [DW-1:0] left_r, left_nxt;
  logic          out_v_r;
  lfhtc_pkg::out_item_t out_d_r;
  logic          emit;
  lfhtc_pkg::out_item_t emit_d;

  // memory ports
  logic          lw, fw, hw;
  logic [AW-1:0] lwa, fwa, hwa, lra, fra, hra;
  logic [DW-1:0] lwd, fwd, hwd, lrd, frd, hrd;

  lfhtc_ram #(.DEPTH(lfhtc_pkg::CAPACITY), .WIDTH(DW)) u_lifo (
    .clk, .we(lw), .waddr(lwa), .wdata(lwd), .raddr(lra), .rdata(lrd));
  lfhtc_ram #(.DEPTH(lfhtc_pkg::CAPACITY), .WIDTH(DW)) u_fifo (
    .clk, .we(fw), .waddr(fwa), .wdata(fwd), .raddr(fra), .rdata(frd));
  lfhtc_ram #(.DEPTH(lfhtc_pkg::CAPACITY), .WIDTH(DW)) u_heap (
    .clk, .we(hw), .waddr(hwa), .wdata(hwd), .raddr(hra), .rdata(hrd));

  function automatic logic sgt(input logic [DW-1:0] a, input logic [DW-1:0] b);
    sgt = $signed(a) > $signed(b);
  endfunction

  logic [CW-1:0] parent, lchild, rchild;
  logic [CW:0]   tail_sum;
  logic          is_idle;

  assign is_idle     = (state_r == S_IDLE);
  // hold off new items while a verdict still waits
  assign in_ch.ready = is_idle && !(out_v_r && !out_ch.ready);
  assign parent      = (pos_r - CW'(1)) >> 1;
  assign lchild      = CW'({pos_r, 1'b1});
  assign rchild      = lchild + CW'(1);
  assign tail_sum    = {1'b0, CW'(head_r)} + {1'b0, fill_r};

  always_comb begin
    state_nxt = state_r; fill_nxt = fill_r; head_nxt = head_r;
    lifo_ok_nxt = lifo_ok_r; fifo_ok_nxt = fifo_ok_r; heap_ok_nxt = heap_ok_r;
    ovf_nxt = ovf_r; pos_nxt = pos_r; val_nxt = val_r; obs_nxt = obs_r;
    left_nxt = left_r;
    lw = 1'b0; fw = 1'b0; hw = 1'b0;
    lwa = fill_r[AW-1:0]; lwd = val_r;
    fwa = (tail_sum >= (CW+1)'(lfhtc_pkg::CAPACITY)) ?
          AW'(tail_sum - (CW+1)'(lfhtc_pkg::CAPACITY)) : AW'(tail_sum);
    fwd = val_r;
    hwa = pos_r[AW-1:0]; hwd = val_r;
    lra = AW'(fill_r - CW'(1)); fra = head_r; hra = '0;
    emit = 1'b0; emit_d = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          val_nxt = in_ch.data.value;
          obs_nxt = in_ch.data.value;
          case (in_ch.data.command)
            lfhtc_pkg::CMD_PUSH: begin
              if (fill_r >= CW'(lfhtc_pkg::CAPACITY)) begin
                lifo_ok_nxt = 1'b0; fifo_ok_nxt = 1'b0; heap_ok_nxt = 1'b0;
                ovf_nxt = 1'b1;
              end else begin
                lw = 1'b1; lwd = in_ch.data.value;
                fw = 1'b1; fwd = in_ch.data.value;
                pos_nxt = fill_r;
                state_nxt = S_PRD;
              end
            end
            lfhtc_pkg::CMD_POP: begin
              if (fill_r == '0) begin
                lifo_ok_nxt = 1'b0; fifo_ok_nxt = 1'b0; heap_ok_nxt = 1'b0;
              end else begin
                hra = '0;
                state_nxt = S_POPA;
              end
            end
            lfhtc_pkg::CMD_END: begin
              emit = 1'b1;
              if ((3'(lifo_ok_r) + 3'(fifo_ok_r) + 3'(heap_ok_r)) > 3'd1)
                emit_d.verdict = lfhtc_pkg::VERD_NOT_SURE;
              else if (lifo_ok_r) emit_d.verdict = lfhtc_pkg::VERD_STACK;
              else if (fifo_ok_r) emit_d.verdict = lfhtc_pkg::VERD_QUEUE;
              else if (heap_ok_r) emit_d.verdict = lfhtc_pkg::VERD_PRIO;
              else emit_d.verdict = lfhtc_pkg::VERD_IMPOSSIBLE;
              emit_d.overflowed = ovf_r;
              fill_nxt = '0; head_nxt = '0; ovf_nxt = 1'b0;
              lifo_ok_nxt = 1'b1; fifo_ok_nxt = 1'b1; heap_ok_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_PRD: begin
        // climb: read the parent, or settle at the root
        if (pos_r == '0) begin
          hw = 1'b1;
          fill_nxt = fill_r + CW'(1);
          state_nxt = S_IDLE;
        end else begin
          hra = parent[AW-1:0];
          state_nxt = S_PCMP;
        end
      end
      S_PCMP: begin
        if (sgt(val_r, hrd)) begin
          hw = 1'b1; hwd = hrd;
          pos_nxt = parent;
          state_nxt = S_PRD;
        end else begin
          hw = 1'b1;
          fill_nxt = fill_r + CW'(1);
          state_nxt = S_IDLE;
        end
      end
      S_POPA: begin
        // top arrives in hrd; stack and queue reads were issued in idle too
        lra = AW'(fill_r - CW'(1)); fra = head_r;
        if (lrd != obs_r) lifo_ok_nxt = 1'b0;
        if (frd != obs_r) fifo_ok_nxt = 1'b0;
        if (hrd != obs_r) heap_ok_nxt = 1'b0;
        head_nxt = (head_r == AW'(lfhtc_pkg::CAPACITY - 1)) ? '0 : head_r + AW'(1);
        fill_nxt = fill_r - CW'(1);
        hra = AW'(fill_r - CW'(1));
        state_nxt = S_POPC;
      end
      S_POPC: begin
        val_nxt = hrd;
        pos_nxt = '0;
        state_nxt = (fill_r == '0) ? S_IDLE : S_DRL;
      end
      S_DRL: begin
        if (lchild >= fill_r) begin
          hw = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          hra = lchild[AW-1:0];
          state_nxt = S_DRR;
        end
      end
      S_DRR: begin
        left_nxt = hrd;
        hra = rchild[AW-1:0];
        state_nxt = S_DCMP;
      end
      S_DCMP: begin
        if ((rchild < fill_r) && sgt(hrd, left_r)) begin
          if (sgt(hrd, val_r)) begin
            hw = 1'b1; hwd = hrd; pos_nxt = rchild; state_nxt = S_DRL;
          end else begin
            hw = 1'b1; state_nxt = S_IDLE;
          end
        end else if (sgt(left_r, val_r)) begin
          hw = 1'b1; hwd = left_r; pos_nxt = lchild; state_nxt = S_DRL;
        end else begin
          hw = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // stack and queue reads must be addressed in idle to land in S_POPA
  // (the address expressions above are the same in both states)

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; fill_r <= '0; head_r <= '0;
      lifo_ok_r <= 1'b1; fifo_ok_r <= 1'b1; heap_ok_r <= 1'b1;
      ovf_r <= 1'b0; out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt; fill_r <= fill_nxt; head_r <= head_nxt;
      lifo_ok_r <= lifo_ok_nxt; fifo_ok_r <= fifo_ok_nxt;
      heap_ok_r <= heap_ok_nxt; ovf_r <= ovf_nxt;
      if (emit) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt; val_r <= val_nxt; obs_r <= obs_nxt; left_r <= left_nxt;
    if (emit) out_d_r <= emit_d;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(lfhtc_pkg::CAPACITY)) else $error("fill count beyond capacity");
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> is_idle) else $error("verdict outside idle");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POPA) |=> (fill_r == $past(fill_r) - CW'(1)))
    else $error("pop did not lower fill count");
  a_sift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DCMP) |-> (pos_r < fill_r)) else $error("sift beyond fill");
`endif
endmodule
